@@ src/swtq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtq_pkg
// Shared types and constants for the sorted wakeup timer queue.
// ----------------------------------------------------------------------------
package swtq_pkg;

  // Field widths of the stream payloads.
  localparam int TICK_W   = 63;
  localparam int ID_W     = 8;
  localparam int DUR_W    = 32;
  localparam int S_DATA_W = 40;  // sleeper_id, sleep_duration
  localparam int M_DATA_W = 72;  // woken_id, tick_count, one pad bit

  // Upper bound on sleepers released by a single tick.
  localparam int MAX_WAKE_PER_TICK = 16;

  // Input operation codes, carried on s_tuser.
  localparam logic OP_SLEEP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result kinds, carried on m_tuser.
  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_WOKEN    = 2'd2,
    KIND_NONE_DUE = 2'd3
  } kind_t;

  // One queue entry as held in the entry RAM.
  typedef struct packed {
    logic [TICK_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_PUT,
    ST_TICK_CHK,
    ST_TICK_END
  } state_t;

endpackage

@@ src/sorted_wakeup_timer_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue_top
// Tick counter with a wake-time sorted queue of sleepers held in one RAM.
// ----------------------------------------------------------------------------
// A rejected insert, an insert into an empty queue or an idle tick gives
// its result in the cycle after acceptance. An insert walks the entries
// in ST_INS_CHK and then writes in ST_INS_PUT; a tick checks the entries
// in ST_TICK_CHK. Throughput: one item at a time, bounded by the single
// RAM read port that each walked entry passes through.
// Reset: synchronous, active high; clears the count and the queue at once.
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Sleep requests and ticks.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] sleeper_id, [39:8] sleep_duration
  input  logic [0:0]  s_tuser,   // [0] operation
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] woken_id, [70:8] tick_count, [71] zero
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast
);

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int OW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM = (QUEUE_DEPTH < swtq_pkg::MAX_WAKE_PER_TICK) ?
                       QUEUE_DEPTH : swtq_pkg::MAX_WAKE_PER_TICK;
  localparam int EW  = $bits(swtq_pkg::entry_t);

  // Control and payload registers.
  swtq_pkg::state_t state, state_next;
  logic [OW-1:0] occ, occ_next;
  logic [swtq_pkg::TICK_W-1:0] cnt, cnt_next;
  logic [swtq_pkg::TICK_W-1:0] wake, wake_next;
  logic [swtq_pkg::ID_W-1:0] pend_id, pend_id_next;
  logic [AW-1:0] addr, addr_next;
  logic [AW-1:0] put_addr, put_addr_next;
  logic [OW-1:0] n, n_next;

  // Output register.
  logic out_valid, out_valid_next;
  swtq_pkg::kind_t out_kind, out_kind_next;
  logic [swtq_pkg::ID_W-1:0] out_id, out_id_next;
  logic [swtq_pkg::TICK_W-1:0] out_tick, out_tick_next;
  logic out_last, out_last_next;

  // RAM interface.
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  swtq_pkg::entry_t ram_wdata, ram_rdata;
  logic [EW-1:0] ram_rdata_raw;

  // Decoded input fields and helpers.
  logic in_op;
  logic [swtq_pkg::ID_W-1:0] in_id;
  logic [swtq_pkg::DUR_W-1:0] in_dur;
  logic [swtq_pkg::TICK_W:0] wake_sum;
  logic [swtq_pkg::TICK_W-1:0] wake_sat;
  logic [swtq_pkg::TICK_W-1:0] cnt_inc;
  logic [OW-1:0] n_inc;
  logic can_emit, in_acc, due;

  assign in_op  = s_tuser[0];
  assign in_id  = s_tdata[7:0];
  assign in_dur = s_tdata[39:8];

  // Wake time saturates at the largest count.
  assign wake_sum = {1'b0, cnt} + (swtq_pkg::TICK_W + 1)'(in_dur);
  assign wake_sat = wake_sum[swtq_pkg::TICK_W] ? '1 : wake_sum[swtq_pkg::TICK_W-1:0];
  assign cnt_inc  = cnt + swtq_pkg::TICK_W'(1);
  assign n_inc    = n + OW'(1);

  assign ram_rdata = swtq_pkg::entry_t'(ram_rdata_raw);
  assign due       = (ram_rdata.wake <= cnt);

  assign can_emit = !out_valid || m_tready;
  assign s_tready = (state == swtq_pkg::ST_IDLE) && can_emit;
  assign in_acc   = s_tvalid && s_tready;

  // Entries are stored front-last: the front of the queue sits at occ - 1.
  swtq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  // Next state, RAM accesses and result generation.
  always_comb begin
    state_next    = state;
    occ_next      = occ;
    cnt_next      = cnt;
    wake_next     = wake;
    pend_id_next  = pend_id;
    addr_next     = addr;
    put_addr_next = put_addr;
    n_next        = n;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = put_addr;
    ram_raddr     = addr;
    ram_wdata     = ram_rdata;
    out_valid_next = m_tready ? 1'b0 : out_valid;
    out_kind_next  = out_kind;
    out_id_next    = out_id;
    out_tick_next  = out_tick;
    out_last_next  = out_last;

    unique case (state)
      swtq_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == swtq_pkg::OP_SLEEP) begin
            if (occ == OW'(QUEUE_DEPTH)) begin
              out_valid_next = 1'b1;
              out_kind_next  = swtq_pkg::KIND_REJECTED;
              out_id_next    = '0;
              out_tick_next  = cnt;
              out_last_next  = 1'b1;
            end else if (occ == '0) begin
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata.wake = wake_sat;
              ram_wdata.id   = in_id;
              occ_next       = occ + OW'(1);
              out_valid_next = 1'b1;
              out_kind_next  = swtq_pkg::KIND_ACCEPTED;
              out_id_next    = '0;
              out_tick_next  = cnt;
              out_last_next  = 1'b1;
            end else begin
              wake_next    = wake_sat;
              pend_id_next = in_id;
              ram_re       = 1'b1;
              ram_raddr    = AW'(occ - OW'(1));
              addr_next    = AW'(occ - OW'(1));
              state_next   = swtq_pkg::ST_INS_CHK;
            end
          end else begin
            cnt_next = cnt_inc;
            if ((cnt_inc == '0) || (occ == '0)) begin
              out_valid_next = 1'b1;
              out_kind_next  = swtq_pkg::KIND_NONE_DUE;
              out_id_next    = '0;
              out_tick_next  = cnt_inc;
              out_last_next  = 1'b1;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = AW'(occ - OW'(1));
              n_next     = '0;
              state_next = swtq_pkg::ST_TICK_CHK;
            end
          end
        end
      end

      // Walk from the front; entries due no later than the new one move up.
      swtq_pkg::ST_INS_CHK: begin
        if (ram_rdata.wake <= wake) begin
          ram_we    = 1'b1;
          ram_waddr = addr + AW'(1);
          ram_wdata = ram_rdata;
          if (addr == '0) begin
            put_addr_next = '0;
            state_next    = swtq_pkg::ST_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = addr - AW'(1);
            addr_next = addr - AW'(1);
          end
        end else begin
          put_addr_next = addr + AW'(1);
          state_next    = swtq_pkg::ST_INS_PUT;
        end
      end

      // Place the new sleeper in the gap and report the transaction.
      swtq_pkg::ST_INS_PUT: begin
        if (can_emit) begin
          ram_we         = 1'b1;
          ram_waddr      = put_addr;
          ram_wdata.wake = wake;
          ram_wdata.id   = pend_id;
          occ_next       = occ + OW'(1);
          out_valid_next = 1'b1;
          out_kind_next  = swtq_pkg::KIND_ACCEPTED;
          out_id_next    = '0;
          out_tick_next  = cnt;
          out_last_next  = 1'b1;
          state_next     = swtq_pkg::ST_IDLE;
        end
      end

      // Check the next entry; the one held before it leaves with last set
      // only when this one is not due.
      swtq_pkg::ST_TICK_CHK: begin
        if (can_emit) begin
          if (n != '0) begin
            out_valid_next = 1'b1;
            out_kind_next  = swtq_pkg::KIND_WOKEN;
            out_id_next    = pend_id;
            out_tick_next  = cnt;
            out_last_next  = !due;
          end else if (!due) begin
            out_valid_next = 1'b1;
            out_kind_next  = swtq_pkg::KIND_NONE_DUE;
            out_id_next    = '0;
            out_tick_next  = cnt;
            out_last_next  = 1'b1;
          end
          if (due) begin
            pend_id_next = ram_rdata.id;
            n_next       = n_inc;
            if ((n_inc < occ) && (n_inc < OW'(LIM))) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(occ - OW'(1) - n_inc);
            end else begin
              state_next = swtq_pkg::ST_TICK_END;
            end
          end else begin
            occ_next   = occ - n;
            state_next = swtq_pkg::ST_IDLE;
          end
        end
      end

      // The last released sleeper closes the tick.
      swtq_pkg::ST_TICK_END: begin
        if (can_emit) begin
          out_valid_next = 1'b1;
          out_kind_next  = swtq_pkg::KIND_WOKEN;
          out_id_next    = pend_id;
          out_tick_next  = cnt;
          out_last_next  = 1'b1;
          occ_next       = occ - n;
          state_next     = swtq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = swtq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swtq_pkg::ST_IDLE;
      occ       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wake     <= wake_next;
    pend_id  <= pend_id_next;
    addr     <= addr_next;
    put_addr <= put_addr_next;
    n        <= n_next;
    out_kind <= out_kind_next;
    out_id   <= out_id_next;
    out_tick <= out_tick_next;
    out_last <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_tick, out_id};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

@@ src/swtq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module swtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read data that holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/swtq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtq_checker
// Port-level checks on the result stream of the sorted wakeup timer queue.
// ----------------------------------------------------------------------------
module swtq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                               && $stable(m_tlast))
    else $error("result changed while stalled");

  // Every kind other than a woken sleeper is the single result of its item.
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != swtq_pkg::KIND_WOKEN) |-> m_tlast)
    else $error("single result without last");

  // Only a woken sleeper carries an identifier.
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != swtq_pkg::KIND_WOKEN) |-> (m_tdata[7:0] == 8'd0))
    else $error("identifier on a result that wakes nobody");

  // No result is presented straight after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_wakeup_timer_queue_top swtq_checker u_checker (.*);

@@ sim/tb_sorted_wakeup_timer_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_wakeup_timer_queue_top
// Self-checking bench for the sorted wakeup timer queue. A short table of
// directed transactions covers an idle tick after reset, identifier and
// duration extremes, equal wake times leaving in arrival order, a rejected
// insert on a full queue and a tick that drains many sleepers. Bursts of
// random sleeps and ticks follow, under several patterns of sender gaps and
// receiver stalls. Every result is compared, field by field, with a typed
// table result or with a timer queue model kept in the bench.
// ----------------------------------------------------------------------------
module tb_sorted_wakeup_timer_queue_top;

  localparam int QDEPTH      = 16;
  localparam int DIR_ROWS    = 24;
  localparam int RAND_PER_PH = 90;
  localparam int TAIL_CYCLES = 2 * QDEPTH + 8;
  localparam logic [swtq_pkg::TICK_W-1:0] TICK_MAX = {swtq_pkg::TICK_W{1'b1}};

  // One result as it leaves the block.
  typedef struct packed {
    swtq_pkg::kind_t             kind;
    logic [swtq_pkg::ID_W-1:0]   id;
    logic [swtq_pkg::TICK_W-1:0] tick;
    logic                        last;
  } wake_result_t;

  // One row of the directed table; a typed row carries its single result.
  typedef struct packed {
    logic                        op;
    logic [swtq_pkg::ID_W-1:0]   id;
    logic [swtq_pkg::DUR_W-1:0]  dur;
    logic                        typed;
    swtq_pkg::kind_t             kind;
    logic [swtq_pkg::TICK_W-1:0] tick;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [7:0] sleeper_id, [39:8] sleep_duration
  logic [0:0]  s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [7:0] woken_id, [70:8] tick_count, [71] zero
  logic [1:0]  m_tuser;   // [1:0] result_kind
  logic        m_tlast;

  // Idling percentages of the current phase.
  int gap_pct;
  int stall_pct;
  int mismatches;

  // Timer queue model: tick counter and sleepers in wake-time order.
  logic [swtq_pkg::TICK_W-1:0] model_tick;
  logic [swtq_pkg::TICK_W-1:0] model_wake [QDEPTH];
  logic [swtq_pkg::ID_W-1:0]   model_who  [QDEPTH];
  int                          model_fill;

  // Results of the last modelled transaction, and results still awaited.
  wake_result_t step_results [$];
  wake_result_t awaited_results [$];

  dir_row_t dir_rows [DIR_ROWS];

  sorted_wakeup_timer_queue_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic flag_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Model one sleep request or tick, leaving its results in step_results.
  task automatic timer_queue_step(input logic op, input logic [swtq_pkg::ID_W-1:0] id,
                                  input logic [swtq_pkg::DUR_W-1:0] dur);
    logic [swtq_pkg::TICK_W:0]   wide_wake;
    logic [swtq_pkg::TICK_W-1:0] wake;
    int                          pos;
    int                          due;
    step_results.delete();
    if (op == swtq_pkg::OP_SLEEP) begin
      if (model_fill >= QDEPTH) begin
        step_results.push_back('{swtq_pkg::KIND_REJECTED, '0, model_tick, 1'b1});
      end else begin
        // Saturate the wake time at the top of the count range.
        wide_wake = {1'b0, model_tick} + (swtq_pkg::TICK_W + 1)'(dur);
        wake = wide_wake[swtq_pkg::TICK_W] ? TICK_MAX : wide_wake[swtq_pkg::TICK_W-1:0];
        // Equal wake times keep their arrival order.
        pos = 0;
        while (pos < model_fill && model_wake[pos] <= wake) pos++;
        for (int i = model_fill; i > pos; i--) begin
          model_wake[i] = model_wake[i-1];
          model_who[i]  = model_who[i-1];
        end
        model_wake[pos] = wake;
        model_who[pos]  = id;
        model_fill++;
        step_results.push_back('{swtq_pkg::KIND_ACCEPTED, '0, model_tick, 1'b1});
      end
    end else begin
      model_tick = model_tick + swtq_pkg::TICK_W'(1);
      due = 0;
      // Nothing leaves on the tick that wraps the count to zero.
      if (model_tick != '0) begin
        while (due < model_fill && due < swtq_pkg::MAX_WAKE_PER_TICK &&
               model_wake[due] <= model_tick)
          due++;
      end
      if (due == 0) begin
        step_results.push_back('{swtq_pkg::KIND_NONE_DUE, '0, model_tick, 1'b1});
      end else begin
        for (int i = 0; i < due; i++)
          step_results.push_back('{swtq_pkg::KIND_WOKEN, model_who[i], model_tick,
                                   i == due - 1});
        for (int i = due; i < model_fill; i++) begin
          model_wake[i-due] = model_wake[i];
          model_who[i-due]  = model_who[i];
        end
        model_fill -= due;
      end
    end
  endtask

  // Offer one transaction after a random gap, model it once accepted and
  // queue its results. A typed result replaces the modelled one.
  task automatic issue_item(input logic op, input logic [swtq_pkg::ID_W-1:0] id,
                            input logic [swtq_pkg::DUR_W-1:0] dur, input logic typed,
                            input wake_result_t typed_res);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {dur, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    timer_queue_step(op, id, dur);
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result with the oldest awaited one.
  always @(posedge clk) begin : result_check
    wake_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d id %0h tick %0d",
                             m_tuser, m_tdata[7:0], m_tdata[70:8]));
      end else begin
        want = awaited_results.pop_front();
        if (m_tuser !== want.kind)
          flag_error($sformatf("kind: expected %0d got %0d", want.kind, m_tuser));
        if (m_tdata[7:0] !== want.id)
          flag_error($sformatf("woken id: expected %0h got %0h", want.id, m_tdata[7:0]));
        if (m_tdata[70:8] !== want.tick)
          flag_error($sformatf("tick count: expected %0d got %0d", want.tick, m_tdata[70:8]));
        if (m_tlast !== want.last)
          flag_error($sformatf("last: expected %0b got %0b", want.last, m_tlast));
      end
    end
  end

  // Directed table: an idle tick, a sleeper that never wakes, a full queue
  // with mixed and equal wake times, a rejected insert, then draining ticks.
  initial begin
    dir_rows = '{
      '{swtq_pkg::OP_TICK,  8'h00, 32'h0000_0000, 1'b1, swtq_pkg::KIND_NONE_DUE, 63'd1},
      '{swtq_pkg::OP_SLEEP, 8'hFF, 32'hFFFF_FFFF, 1'b1, swtq_pkg::KIND_ACCEPTED, 63'd1},
      '{swtq_pkg::OP_SLEEP, 8'h00, 32'h0000_0000, 1'b1, swtq_pkg::KIND_ACCEPTED, 63'd1},
      '{swtq_pkg::OP_SLEEP, 8'h55, 32'h0000_0002, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h01, 32'h0000_0001, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'hAA, 32'h0000_0000, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h02, 32'h0000_0002, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h80, 32'h0000_0001, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h7F, 32'h0000_0000, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h03, 32'h0000_0001, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'hFE, 32'h0000_0002, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h04, 32'h0000_0000, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h05, 32'h0000_0001, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h06, 32'h0000_0002, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h07, 32'h0000_0000, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h08, 32'h0000_0001, 1'b0, swtq_pkg::KIND_ACCEPTED, 63'd0},
      '{swtq_pkg::OP_SLEEP, 8'h09, 32'h0000_0003, 1'b1, swtq_pkg::KIND_ACCEPTED, 63'd1},
      '{swtq_pkg::OP_SLEEP, 8'hC3, 32'h0000_0000, 1'b1, swtq_pkg::KIND_REJECTED, 63'd1},
      '{swtq_pkg::OP_TICK,  8'h00, 32'h0000_0000, 1'b0, swtq_pkg::KIND_WOKEN,    63'd0},
      '{swtq_pkg::OP_TICK,  8'h00, 32'h0000_0000, 1'b0, swtq_pkg::KIND_WOKEN,    63'd0},
      '{swtq_pkg::OP_TICK,  8'h00, 32'h0000_0000, 1'b0, swtq_pkg::KIND_WOKEN,    63'd0},
      '{swtq_pkg::OP_TICK,  8'h00, 32'h0000_0000, 1'b1, swtq_pkg::KIND_NONE_DUE, 63'd5},
      '{swtq_pkg::OP_SLEEP, 8'h3C, 32'h0000_0000, 1'b1, swtq_pkg::KIND_ACCEPTED, 63'd5},
      '{swtq_pkg::OP_TICK,  8'h00, 32'h0000_0000, 1'b0, swtq_pkg::KIND_WOKEN,    63'd0}
    };
  end

  // Stimulus: reset, directed table, then random bursts in four phases.
  initial begin : stimulus
    int                         burst_left;
    int                         fill_pct;
    int                         far_left;
    int                         r;
    logic                       op;
    logic [swtq_pkg::ID_W-1:0]  id;
    logic [swtq_pkg::DUR_W-1:0] dur;
    int                         phase_gap   [4];
    int                         phase_stall [4];
    phase_gap   = '{0, 54, 0, 25};
    phase_stall = '{0, 0, 54, 25};
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= swtq_pkg::OP_SLEEP;
    gap_pct     = 0;
    stall_pct   = 0;
    mismatches  = 0;
    model_tick  = '0;
    model_fill  = 0;
    burst_left  = 0;
    fill_pct    = 50;
    far_left    = 3;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      issue_item(dir_rows[k].op, dir_rows[k].id, dir_rows[k].dur, dir_rows[k].typed,
                 '{dir_rows[k].kind, '0, dir_rows[k].tick, 1'b1});
    end

    // Bursts lean towards either filling or draining the queue, so that it
    // runs full and ticks release many sleepers at once.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      for (int k = 0; k < RAND_PER_PH; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(4, 16);
          fill_pct   = $urandom_range(1) ? 85 : 30;
        end
        burst_left--;
        op = ($urandom_range(99) < fill_pct) ? swtq_pkg::OP_SLEEP : swtq_pkg::OP_TICK;
        id = swtq_pkg::ID_W'($urandom_range(0, 255));
        // A few sleepers may never wake; they are capped so the queue stays usable.
        r = $urandom_range(99);
        if (r < 2 && far_left > 0) begin
          dur = $urandom;
          far_left--;
        end else if (r < 12) begin
          dur = $urandom_range(13, 60);
        end else begin
          dur = $urandom_range(0, 12);
        end
        issue_item(op, id, dur, 1'b0, '{swtq_pkg::KIND_ACCEPTED, '0, '0, 1'b0});
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(10_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
